/* hw/rtl/wsgm_pkg.sv */
// Shared constants and beat types for the star-only glob match core.
`default_nettype none

package wsgm_pkg;

    localparam int MAX_PATTERN_DEFAULT = 64;

    localparam logic [7:0] STAR_CHAR = 8'd42;

    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_NAME    = 1'b1;

    // One beat as it travels down the cell chain.
    typedef struct packed {
        logic       valid;
        logic       is_name;
        logic       first;
        logic       last;
        logic       ovf;
        logic       new_pat;
        logic       wr_en;
        logic [7:0] ch;
    } wsgm_beat_t;

    // Match state handed from one cell to the next for the same beat.
    typedef struct packed {
        logic act;
        logic init;
        logic acc;
    } wsgm_link_t;

endpackage

`default_nettype wire

/* hw/rtl/wsgm_cell.sv */
// One pattern position of the match chain: stored element, active bit and hand-off registers.
`default_nettype none

module wsgm_cell #(
    parameter int IDX_W    = $clog2(wsgm_pkg::MAX_PATTERN_DEFAULT),
    parameter int CELL_IDX = 0
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      advance,
    input  wsgm_pkg::wsgm_beat_t     beat_in,
    input  wire  [IDX_W-1:0]         wr_idx_in,
    input  wsgm_pkg::wsgm_link_t     link_in,
    output wsgm_pkg::wsgm_beat_t     beat_out,
    output logic [IDX_W-1:0]         wr_idx_out,
    output wsgm_pkg::wsgm_link_t     link_out
);

    logic [7:0]            char_reg;
    logic                  star_reg;
    logic                  pat_valid_reg;
    logic                  act_reg;
    wsgm_pkg::wsgm_beat_t  beat_reg;
    logic [IDX_W-1:0]      wr_idx_reg;
    wsgm_pkg::wsgm_link_t  link_reg;

    logic                  prev;
    logic                  star_ok;
    logic                  lit_ok;
    logic                  a_now;
    logic                  take;
    logic                  wr_hit;
    wsgm_pkg::wsgm_link_t  link_next;

    assign take    = advance && beat_in.valid;
    assign wr_hit  = beat_in.wr_en && (wr_idx_in == IDX_W'(CELL_IDX));
    assign prev    = beat_in.first ? link_in.init : act_reg;
    assign star_ok = pat_valid_reg && star_reg;
    assign lit_ok  = pat_valid_reg && !star_reg && (char_reg == beat_in.ch);
    assign a_now   = (prev && star_ok) || link_in.act;

    always_comb
    begin
        link_next.act  = (prev && lit_ok) || (a_now && star_ok);
        link_next.init = link_in.init && star_ok;
        link_next.acc  = link_in.acc || (!pat_valid_reg && a_now);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_valid_reg <= 1'b0;
            star_reg      <= 1'b0;
            act_reg       <= 1'b0;
        end
        else if (take)
        begin
            if (beat_in.is_name)
            begin
                act_reg <= a_now;
            end
            else
            begin
                if (beat_in.new_pat)
                begin
                    pat_valid_reg <= 1'b0;
                end
                if (wr_hit)
                begin
                    pat_valid_reg <= 1'b1;
                    star_reg      <= (beat_in.ch == wsgm_pkg::STAR_CHAR);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !beat_in.is_name && wr_hit)
        begin
            char_reg <= beat_in.ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg   <= '0;
            wr_idx_reg <= '0;
            link_reg   <= '0;
        end
        else if (advance)
        begin
            beat_reg   <= beat_in;
            wr_idx_reg <= wr_idx_in;
            link_reg   <= link_next;
        end
    end

    assign beat_out   = beat_reg;
    assign wr_idx_out = wr_idx_reg;
    assign link_out   = link_reg;

endmodule

`default_nettype wire

/* hw/rtl/wildcard_star_glob_match_core.sv */
// Top level of the star-only glob match core: input bookkeeping, cell chain and output register.
// Path: an accepted beat passes down the one-register-per-cell chain, whose last stage feeds
// the output register that drives m_tvalid.
// Throughput: one beat per cycle; s_tready drops only when the output register is full, not
// taken, and the chain end holds another result.
// Reset: pattern empty, no name in progress, output empty; no clearing pass is needed.
`default_nettype none

module wildcard_star_glob_match_core #(
    parameter int MAX_PATTERN = wsgm_pkg::MAX_PATTERN_DEFAULT
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // [7:0] char_byte
    input  wire        s_tlast,
    input  wire  [0:0] s_tuser,   // [0] opcode
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [LEN_W-1:0] pattern_length_reg;
    logic [LEN_W-1:0] pattern_length_next;
    logic             overflow_reg;
    logic             overflow_next;
    logic             start_new_reg;
    logic             start_new_next;
    logic             name_active_reg;
    logic             name_active_next;

    logic             out_valid_reg;
    logic             out_matched_reg;
    logic             out_ovf_reg;

    logic             advance;
    logic             accept;
    logic             is_name;
    logic [LEN_W-1:0] base_len;
    logic             wr_en;
    logic             q_result;
    logic             load_out;

    wsgm_pkg::wsgm_beat_t beat_chain [0:MAX_PATTERN];
    wsgm_pkg::wsgm_link_t link_chain [0:MAX_PATTERN];
    logic [IDX_W-1:0]     idx_chain  [0:MAX_PATTERN];

    assign is_name  = (s_tuser[0] == wsgm_pkg::OP_NAME);
    assign base_len = start_new_reg ? '0 : pattern_length_reg;
    assign wr_en    = (base_len < LEN_W'(MAX_PATTERN));

    assign q_result = beat_chain[MAX_PATTERN].valid && beat_chain[MAX_PATTERN].is_name
                      && beat_chain[MAX_PATTERN].last;
    assign advance  = !q_result || !out_valid_reg || m_tready;
    assign load_out = q_result && advance;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    assign beat_chain[0] = '{valid:   s_tvalid,
                             is_name: is_name,
                             first:   !name_active_reg,
                             last:    s_tlast,
                             ovf:     overflow_reg,
                             new_pat: start_new_reg,
                             wr_en:   !is_name && wr_en,
                             ch:      s_tdata};
    assign idx_chain[0]  = base_len[IDX_W-1:0];
    assign link_chain[0] = '{act: 1'b0, init: 1'b1, acc: 1'b0};

    always_comb
    begin
        pattern_length_next = pattern_length_reg;
        overflow_next       = overflow_reg;
        start_new_next      = start_new_reg;
        name_active_next    = name_active_reg;
        if (accept)
        begin
            if (is_name)
            begin
                name_active_next = !s_tlast;
            end
            else
            begin
                pattern_length_next = wr_en ? base_len + LEN_W'(1) : base_len;
                overflow_next       = (!start_new_reg && overflow_reg) || !wr_en;
                start_new_next      = s_tlast;
                name_active_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            overflow_reg       <= 1'b0;
            start_new_reg      <= 1'b1;
            name_active_reg    <= 1'b0;
        end
        else
        begin
            pattern_length_reg <= pattern_length_next;
            overflow_reg       <= overflow_next;
            start_new_reg      <= start_new_next;
            name_active_reg    <= name_active_next;
        end
    end

    for (genvar gi = 0; gi < MAX_PATTERN; gi++)
    begin : g_cell
        wsgm_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (gi)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .beat_in    (beat_chain[gi]),
            .wr_idx_in  (idx_chain[gi]),
            .link_in    (link_chain[gi]),
            .beat_out   (beat_chain[gi+1]),
            .wr_idx_out (idx_chain[gi+1]),
            .link_out   (link_chain[gi+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_matched_reg <= link_chain[MAX_PATTERN].acc || link_chain[MAX_PATTERN].act;
            out_ovf_reg     <= beat_chain[MAX_PATTERN].ovf;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_ovf_reg, out_matched_reg};

    // A result at the chain end behind a stalled output register must freeze the input side.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (q_result && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while the chain end could not drain");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pattern_length_reg <= LEN_W'(MAX_PATTERN))
        else $error("stored pattern length exceeds capacity");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (pattern_length_reg == LEN_W'(MAX_PATTERN)))
        else $error("overflow flagged with a pattern below capacity");

    a_pattern_ends_name: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_name) |=> !name_active_reg)
        else $error("name still in progress after a pattern beat");

endmodule

`default_nettype wire
